@@ rtl/bounding_sphere_merge_unit_macros.svh @@
// Assertion macros for the sphere merge block
`ifndef BOUNDING_SPHERE_MERGE_UNIT_MACROS_SVH
`define BOUNDING_SPHERE_MERGE_UNIT_MACROS_SVH

// Assert an implication on every clock edge outside reset
`define BSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication whose consequence is checked in the next cycle
`define BSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bsm_pkg.sv @@
//------------------------------------------------------------------------------
// bsm_pkg
// Shared widths and constants of the sphere merge block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package bsm_pkg;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadW    = 31;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned SqW     = 68;
  localparam int unsigned RootW   = 34;
  localparam int unsigned RemW    = 36;
  localparam int unsigned LerpW   = 17;
  localparam int unsigned DivSteps = 17;
  localparam logic [RadW-1:0] RadMax = {RadW{1'b1}};
  localparam logic [LerpW-1:0] LerpOne = 17'h10000;
  localparam logic OpInit = 1'b0;
  localparam logic OpAdd  = 1'b1;
endpackage

@@ rtl/bounding_sphere_merge_unit.sv @@
// Path from the accepting edge to out_tvalid: init or zero item radius goes straight to the
// result; coincident centres or containment stop after the root; a full merge runs every step
// (1 difference, 3 squares, 34 root steps, 1 radius, 17 divide steps, 3 centre updates).
// One 34x34-bit multiplier, shared under the sequencer.
// One transaction in flight; in_tready is low until the result is taken, so no new
// transaction is accepted before the last result has left.
//------------------------------------------------------------------------------
// bounding_sphere_merge_unit
// Merges one sphere per transaction into an accumulated enclosing sphere, or with init replaces it.
// rst_n synchronous active low clears the sphere to zero and the control.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounding_sphere_merge_unit_macros.svh"
module bounding_sphere_merge_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // item_center_x, item_center_y, item_center_z, item_radius, pad
  input  logic         in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // out_center_x, out_center_y, out_center_z, out_radius, pad
  output logic         out_tuser  // radius_saturated
);
  localparam int unsigned CW = bsm_pkg::CoordW;
  localparam int unsigned RW = bsm_pkg::RadW;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_ROOT, S_RNEW, S_DIV, S_SCALE, S_OUT
  } state_t;

  state_t state_r;
  logic [CW-1:0] acx_r, acy_r, acz_r;
  logic [RW-1:0] acr_r;
  logic [CW-1:0] ix_r, iy_r, iz_r;
  logic [RW-1:0] ir_r;
  logic          op_r;
  logic signed [bsm_pkg::DiffW-1:0] d_r [3];
  logic [bsm_pkg::SqW-1:0]   sq_r;
  logic [bsm_pkg::RootW-1:0] root_r;
  logic [bsm_pkg::RemW-1:0]  rem_r;
  logic [5:0]  cnt_r;
  logic [1:0]  ax_r;
  logic [bsm_pkg::RootW:0]   rnew_r;
  logic [50:0] num_r;
  logic [bsm_pkg::LerpW-1:0] lerp_r;
  logic        sat_r;
  logic        out_valid_r;

  // shared multiplier
  logic [33:0] mul_a, mul_b;
  logic [67:0] mul_p;
  assign mul_p = 68'(mul_a) * 68'(mul_b);

  logic [32:0] mag_cur;
  logic signed [32:0] dcur;
  always_comb begin
    dcur    = d_r[ax_r];
    mag_cur = dcur[32] ? 33'(-dcur) : 33'(dcur);
    mul_a   = {1'b0, mag_cur};
    mul_b   = (state_r == S_SQ) ? {1'b0, mag_cur} : 34'(lerp_r);
  end

  // root step
  logic [1:0]  pair;
  logic [bsm_pkg::RemW-1:0] rem_sh, trial;
  always_comb begin
    pair   = sq_r[67:66];
    rem_sh = {rem_r[bsm_pkg::RemW-3:0], pair};
    trial  = {root_r[bsm_pkg::RemW-3:0], 2'b01};
  end

  // divide step: num/dist restoring, quotient bits into lerp
  logic [51:0] dsub;
  assign dsub = {1'b0, num_r} - {18'd0, root_r};

  logic [35:0] rsum;
  assign rsum = 36'(root_r) + 36'(acr_r) + 36'(ir_r);

  logic [49:0] offs;
  logic [32:0] soff;
  logic [CW-1:0] newc;
  always_comb begin
    offs = mul_p[65:16];
    soff = dcur[32] ? 33'(-offs[32:0]) : offs[32:0];
    newc = 32'(33'(signed'(ax_r == 2'd0 ? acx_r : ax_r == 2'd1 ? acy_r : acz_r))
               + soff);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, acr_r, acz_r, acy_r, acx_r};
  assign out_tuser  = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      acx_r <= '0; acy_r <= '0; acz_r <= '0; acr_r <= '0; sat_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tuser;
          ix_r <= in_tdata[31:0]; iy_r <= in_tdata[63:32];
          iz_r <= in_tdata[95:64]; ir_r <= in_tdata[126:96];
          sat_r <= 1'b0;
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          if (op_r == bsm_pkg::OpInit) begin
            acx_r <= ix_r; acy_r <= iy_r; acz_r <= iz_r; acr_r <= ir_r;
            state_r <= S_OUT; out_valid_r <= 1'b1;
          end else if (ir_r == '0) begin
            state_r <= S_OUT; out_valid_r <= 1'b1;
          end else begin
            d_r[0] <= 33'(signed'(ix_r)) - 33'(signed'(acx_r));
            d_r[1] <= 33'(signed'(iy_r)) - 33'(signed'(acy_r));
            d_r[2] <= 33'(signed'(iz_r)) - 33'(signed'(acz_r));
            ax_r <= 2'd0; sq_r <= '0; state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= sq_r + mul_p;
          if (ax_r == 2'd2) begin
            ax_r <= 2'd0; cnt_r <= 6'd33; root_r <= '0; rem_r <= '0;
            state_r <= S_ROOT;
          end else ax_r <= ax_r + 2'd1;
        end
        S_ROOT: begin
          sq_r <= {sq_r[65:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_r <= rem_sh - trial; root_r <= {root_r[32:0], 1'b1};
          end else begin
            rem_r <= rem_sh; root_r <= {root_r[32:0], 1'b0};
          end
          if (cnt_r == '0) state_r <= S_RNEW;
          else cnt_r <= cnt_r - 6'd1;
        end
        S_RNEW: begin
          rnew_r <= rsum[35:1];
          if (root_r == '0) begin
            if (ir_r > acr_r) acr_r <= ir_r;
            state_r <= S_OUT; out_valid_r <= 1'b1;
          end else if (rsum[35:1] < 35'(acr_r)) begin
            state_r <= S_OUT; out_valid_r <= 1'b1;
          end else if (rsum[35:1] < 35'(ir_r)) begin
            acx_r <= ix_r; acy_r <= iy_r; acz_r <= iz_r; acr_r <= ir_r;
            state_r <= S_OUT; out_valid_r <= 1'b1;
          end else begin
            // num = rnew - R, aligned so first step yields quotient bit 16
            num_r <= 51'(rsum[35:1] - 35'(acr_r));
            lerp_r <= '0; cnt_r <= 6'(bsm_pkg::DivSteps - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // remainder-left restoring divide of num*2^16 by dist, 17 bits (quotient <2^17 clipped)
          if (dsub[51] == 1'b0) begin
            num_r <= {dsub[49:0], 1'b0}; lerp_r <= {lerp_r[15:0], 1'b1};
          end else begin
            num_r <= {num_r[49:0], 1'b0}; lerp_r <= {lerp_r[15:0], 1'b0};
          end
          if (cnt_r == '0) state_r <= S_SCALE;
          else cnt_r <= cnt_r - 6'd1;
        end
        S_SCALE: begin
          if (lerp_r > bsm_pkg::LerpOne && ax_r == 2'd0) lerp_r <= bsm_pkg::LerpOne;
          else begin
            unique case (ax_r)
              2'd0: acx_r <= newc;
              2'd1: acy_r <= newc;
              default: acz_r <= newc;
            endcase
            if (ax_r == 2'd2) begin
              if (rnew_r > 35'(bsm_pkg::RadMax)) begin
                acr_r <= bsm_pkg::RadMax; sat_r <= 1'b1;
              end else acr_r <= rnew_r[RW-1:0];
              state_r <= S_OUT; out_valid_r <= 1'b1;
            end else ax_r <= ax_r + 2'd1;
          end
        end
        S_OUT: if (out_tready) begin
          out_valid_r <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BSM_ASSERT_IMPL(a_ready_idle, out_tvalid, !in_tready, "ready while result pending")
  `BSM_ASSERT_IMPL(a_sat_radius, out_tvalid && out_tuser, acr_r == bsm_pkg::RadMax, "sat no clamp")
  `BSM_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "accept did not go busy")
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the sphere merge unit. A queue-fed driver sends
// init and add transactions, a software sphere tracker predicts each result,
// and a monitor compares every returned sphere field by field.
//------------------------------------------------------------------------------
module tb;
  typedef struct packed {
    logic                       op;
    logic [bsm_pkg::CoordW-1:0] cx;
    logic [bsm_pkg::CoordW-1:0] cy;
    logic [bsm_pkg::CoordW-1:0] cz;
    logic [bsm_pkg::RadW-1:0]   r;
  } sphere_item_t;

  typedef struct packed {
    logic [bsm_pkg::CoordW-1:0] cx;
    logic [bsm_pkg::CoordW-1:0] cy;
    logic [bsm_pkg::CoordW-1:0] cz;
    logic [bsm_pkg::RadW-1:0]   r;
    logic                       sat;
  } sphere_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;

  sphere_item_t pending_items[$];
  sphere_res_t  expected_spheres[$];
  int unsigned  send_idle_pct = 27;
  int unsigned  recv_idle_pct = 46;
  int unsigned  mismatches = 0;
  int unsigned  spheres_checked = 0;
  int unsigned  saturations = 0;
  int unsigned  merges = 0;

  // tracked sphere
  logic signed [bsm_pkg::CoordW-1:0] acc_x = '0, acc_y = '0, acc_z = '0;
  logic [bsm_pkg::RadW-1:0]          acc_r = '0;

  bounding_sphere_merge_unit DUT (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] root_of_sum(input logic [67:0] v);
    logic [63:0] root, rem, trial;
    root = '0;
    rem = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 64'(v[2*i +: 2]);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [63:0] scaled_offset(input logic signed [63:0] d,
                                                        input logic [63:0] lerp);
    logic [63:0] m;
    m = ((d < 0 ? -d : d) * lerp) >> 16;
    return d < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic sphere_res_t merge_sphere(input sphere_item_t it);
    logic signed [63:0] dx, dy, dz;
    logic [63:0] mx, my, mz, span, rnew, lerp;
    logic [67:0] sq;
    sphere_res_t res;
    logic sat;
    sat = 1'b0;
    if (it.op == bsm_pkg::OpInit) begin
      acc_x = it.cx; acc_y = it.cy; acc_z = it.cz; acc_r = it.r;
    end else if (it.r != 0) begin
      dx = 64'($signed(it.cx)) - 64'(acc_x);
      dy = 64'($signed(it.cy)) - 64'(acc_y);
      dz = 64'($signed(it.cz)) - 64'(acc_z);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      mz = dz < 0 ? -dz : dz;
      sq = 68'(mx * mx) + 68'(my * my) + 68'(mz * mz);
      span = root_of_sum(sq);
      if (span == 0) begin
        if (it.r > acc_r) acc_r = it.r;
      end else begin
        rnew = (span + 64'(acc_r) + 64'(it.r)) >> 1;
        if (rnew < 64'(acc_r)) begin
        end else if (rnew < 64'(it.r)) begin
          acc_x = it.cx; acc_y = it.cy; acc_z = it.cz; acc_r = it.r;
        end else begin
          merges++;
          lerp = ((rnew - 64'(acc_r)) << 16) / span;
          if (lerp > 64'(bsm_pkg::LerpOne)) lerp = 64'(bsm_pkg::LerpOne);
          acc_x = 32'(64'(acc_x) + scaled_offset(dx, lerp));
          acc_y = 32'(64'(acc_y) + scaled_offset(dy, lerp));
          acc_z = 32'(64'(acc_z) + scaled_offset(dz, lerp));
          if (rnew > 64'(bsm_pkg::RadMax)) begin
            acc_r = bsm_pkg::RadMax;
            sat = 1'b1;
          end else begin
            acc_r = rnew[bsm_pkg::RadW-1:0];
          end
        end
      end
    end
    res.cx = acc_x; res.cy = acc_y; res.cz = acc_z; res.r = acc_r; res.sat = sat;
    return res;
  endfunction

  function automatic logic [bsm_pkg::CoordW-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom();
      default: return 32'($signed($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic [bsm_pkg::RadW-1:0] pick_radius();
    case ($urandom_range(11))
      0:       return '0;
      1:       return bsm_pkg::RadMax;
      2, 3:    return 31'($urandom());
      default: return 31'($urandom_range(1048576));
    endcase
  endfunction

  function automatic sphere_item_t make_item(input logic op,
                                             input logic [bsm_pkg::CoordW-1:0] x,
                                             input logic [bsm_pkg::CoordW-1:0] y,
                                             input logic [bsm_pkg::CoordW-1:0] z,
                                             input logic [bsm_pkg::RadW-1:0] r);
    sphere_item_t it;
    it.op = op; it.cx = x; it.cy = y; it.cz = z; it.r = r;
    return it;
  endfunction

  function automatic sphere_item_t random_item();
    return make_item(($urandom_range(9) == 0) ? bsm_pkg::OpInit : bsm_pkg::OpAdd,
                     pick_coord(), pick_coord(), pick_coord(), pick_radius());
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sphere_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= it.op;
        in_tdata  <= {1'b0, it.r, it.cz, it.cy, it.cx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_spheres.push_back(merge_sphere(make_item(in_tuser, in_tdata[31:0],
                                   in_tdata[63:32], in_tdata[95:64], in_tdata[126:96])));
      if (out_tvalid && out_tready) begin
        sphere_res_t got, exp_s;
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tdata[126:96],
               out_tuser};
        if (expected_spheres.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", got);
        end else begin
          exp_s = expected_spheres.pop_front();
          spheres_checked++;
          if (exp_s.sat) saturations++;
          if (got !== exp_s) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp x=%h y=%h z=%h r=%h sat=%b, ",
                        "got x=%h y=%h z=%h r=%h sat=%b"},
                       exp_s.cx, exp_s.cy, exp_s.cz, exp_s.r, exp_s.sat,
                       got.cx, got.cy, got.cz, got.r, got.sat);
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_spheres.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: add onto reset sphere, extremes, zero radius, coincident, containment
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'h0001_0000, 0, 0, 31'h0000_8000));
    pending_items.push_back(make_item(bsm_pkg::OpInit, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, bsm_pkg::RadMax));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, bsm_pkg::RadMax));
    pending_items.push_back(make_item(bsm_pkg::OpInit, 0, 0, 0, '0));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'h0005_0000, 0, 0, '0));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 0, 0, 0, 31'h0002_0000));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 0, 0, 0, 31'h0001_0000));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'h0000_8000, 0, 0, 31'h0000_1000));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'h0001_0000, 0, 0, 31'h0010_0000));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'hFFF0_0000, 32'h0010_0000,
                                      32'h0003_0000, 31'h0004_0000));
    pending_items.push_back(make_item(bsm_pkg::OpInit, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h8000_0000, 31'h0000_0001));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h7FFF_FFFF, 31'h0000_0001));
    pending_items.push_back(make_item(bsm_pkg::OpAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 31'h4000_0000));
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 650; i++) pending_items.push_back(random_item());
      drain();  // sender holds off until every result is back
      send_idle_pct = (p == 0) ? 46 : 0;
      recv_idle_pct = (p == 0) ? 27 : 0;
    end
    repeat (100) @(posedge clk);
    $display("checked %0d spheres: %0d true merges, %0d saturated radii",
             spheres_checked, merges, saturations);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_spheres.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/bsm_pkg.sv
rtl/bounding_sphere_merge_unit.sv
tb/tb.sv
